FILE: rtl/tdf_pkg.sv
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared widths, limits and types of the trial-division factorizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tdf_pkg;

    // Input value and output prime
    localparam int VALUE_W     = 31;
    localparam int PRIME_W     = 31;
    localparam int EXP_W       = 5;

    // Sieve range and prime table
    localparam int SIEVE_LIMIT = 65536;
    localparam int SIEVE_W     = $clog2(SIEVE_LIMIT);
    localparam int MARK_W      = SIEVE_W + 1;
    localparam int PRIME_DEPTH = 6542;          // primes below SIEVE_LIMIT
    localparam int PIDX_W      = $clog2(PRIME_DEPTH);
    localparam int PCNT_W      = $clog2(PRIME_DEPTH + 1);
    localparam int SQ_W        = 2 * SIEVE_W;

    // Results per value
    localparam int MAX_RESULTS = 9;
    localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

    // Stream widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - PRIME_W - EXP_W;

    // Divider status
    typedef struct packed {
        logic               done;
        logic               rem_zero;
        logic [VALUE_W-1:0] quot;
    } t_div_res;

    // Sieve status
    typedef struct packed {
        logic              done;
        logic [PCNT_W-1:0] count;
    } t_sieve_stat;

endpackage

`default_nettype wire

FILE: rtl/tdf_divider.sv
// ----------------------------------------------------------------------------
// tdf_divider
// Restoring radix-2 divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [tdf_pkg::VALUE_W-1:0]   i_dividend,
    input  wire logic [tdf_pkg::SIEVE_W-1:0]   i_divisor,
    output tdf_pkg::t_div_res                  o_res
);
    import tdf_pkg::*;

    localparam int CNT_W = $clog2(VALUE_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [SIEVE_W-1:0] r_rem;
    logic [SIEVE_W-1:0] r_d;
    logic [VALUE_W-1:0] r_quo;

    logic [SIEVE_W:0]   trial;
    logic               fits;
    logic [SIEVE_W:0]   diff;

    assign trial = {r_rem, r_quo[VALUE_W-1]};
    assign fits  = (trial >= {1'b0, r_d});
    assign diff  = trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_d    <= i_divisor;
            r_quo  <= i_dividend;
        end else if (r_busy) begin
            // shift in one dividend bit, subtract when it fits
            r_rem <= fits ? diff[SIEVE_W-1:0] : trial[SIEVE_W-1:0];
            r_quo <= {r_quo[VALUE_W-2:0], fits};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_res.done     = r_done;
    assign o_res.rem_zero = (r_rem == '0);
    assign o_res.quot     = r_quo;

endmodule

`default_nettype wire

FILE: rtl/tdf_sieve.sv
// ----------------------------------------------------------------------------
// tdf_sieve
// Eratosthenes sieve after reset; holds the composite marks and the
// prime table, and serves table reads from a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_sieve (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [tdf_pkg::PIDX_W-1:0]  i_rd_idx,
    output logic [tdf_pkg::SIEVE_W-1:0]      o_rd_prime,
    output tdf_pkg::t_sieve_stat             o_stat
);
    import tdf_pkg::*;

    typedef enum logic [2:0] {
        SV_CLEAR,
        SV_RD,
        SV_CHK,
        SV_MARK,
        SV_DONE
    } t_sv_state;

    t_sv_state          r_state;
    logic [MARK_W-1:0]  r_k;
    logic [MARK_W-1:0]  r_m;
    logic [PCNT_W-1:0]  r_pcnt;

    // composite marks
    logic               mark_mem [SIEVE_LIMIT];
    logic               r_mark_q;
    logic               mark_we;
    logic [SIEVE_W-1:0] mark_wa;
    logic               mark_wd;

    // prime table
    logic [SIEVE_W-1:0] prime_mem [PRIME_DEPTH];
    logic [SIEVE_W-1:0] r_prime_q;
    logic               prime_we;

    logic [SQ_W-1:0]    sq;
    logic [MARK_W-1:0]  m_next;

    assign sq     = SQ_W'(r_k[SIEVE_W-1:0]) * SQ_W'(r_k[SIEVE_W-1:0]);
    assign m_next = r_m + r_k;

    always_comb begin
        mark_we  = 1'b0;
        mark_wa  = r_k[SIEVE_W-1:0];
        mark_wd  = 1'b0;
        prime_we = 1'b0;
        unique case (r_state)
            SV_CLEAR: mark_we = 1'b1;
            SV_CHK:   prime_we = !r_mark_q && (r_pcnt < PCNT_W'(PRIME_DEPTH));
            SV_MARK: begin
                mark_we = 1'b1;
                mark_wa = r_m[SIEVE_W-1:0];
                mark_wd = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            mark_mem[mark_wa] <= mark_wd;
        end
        r_mark_q <= mark_mem[r_k[SIEVE_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (prime_we) begin
            prime_mem[r_pcnt[PIDX_W-1:0]] <= r_k[SIEVE_W-1:0];
        end
        r_prime_q <= prime_mem[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SV_CLEAR;
            r_k     <= '0;
            r_pcnt  <= '0;
        end else begin
            unique case (r_state)
                SV_CLEAR: begin
                    if (r_k == MARK_W'(SIEVE_LIMIT - 1)) begin
                        r_k     <= MARK_W'(2);
                        r_state <= SV_RD;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                SV_RD: begin
                    r_state <= (r_k == MARK_W'(SIEVE_LIMIT)) ? SV_DONE : SV_CHK;
                end
                SV_CHK: begin
                    if (!r_mark_q) begin
                        if (prime_we) begin
                            r_pcnt <= r_pcnt + 1'b1;
                        end
                        if (sq < SQ_W'(SIEVE_LIMIT)) begin
                            r_m     <= sq[MARK_W-1:0];
                            r_state <= SV_MARK;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= SV_RD;
                        end
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= SV_RD;
                    end
                end
                SV_MARK: begin
                    if (m_next >= MARK_W'(SIEVE_LIMIT)) begin
                        r_k     <= r_k + 1'b1;
                        r_state <= SV_RD;
                    end else begin
                        r_m <= m_next;
                    end
                end
                SV_DONE: ;
                default: r_state <= SV_CLEAR;
            endcase
        end
    end

    assign o_rd_prime   = r_prime_q;
    assign o_stat.done  = (r_state == SV_DONE);
    assign o_stat.count = r_pcnt;

endmodule

`default_nettype wire

FILE: rtl/trial_division_factorizer.sv
// ----------------------------------------------------------------------------
// trial_division_factorizer
// Prime factorization of a 31-bit value by trial division over a sieved
// prime table, one output beat per distinct prime in ascending order.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata bits                         | tlast
//  ---------+-----+------------------------------------+----------------------
//  s (in)   | in  | [30:0] value, [31] zero            | -
//  m (out)  | out | [30:0] prime_factor, [35:31]       | last factor of value
//           |     | exponent, [39:36] zero             |
//
//  After reset the mark memory is cleared and the sieve runs; o_s_tready
//  stays low until the table is done. Each table prime is read, squared,
//  compared and then waits on the 31-step shared divider; each extra division
//  by a factor reruns the divider. Values 0 and 1 give no beats.
//  A factor waits in a pending register until the run's end is known; a stalled
//  output beat holds the sequencer only when a new beat must be loaded.
//
`default_nettype none

module trial_division_factorizer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [tdf_pkg::IN_TDATA_W-1:0]    i_s_tdata,   // value
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [tdf_pkg::OUT_TDATA_W-1:0]        o_m_tdata,   // prime_factor, exponent
    output logic                                   o_m_tlast    // last_factor
);
    import tdf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_SQR,
        S_CMP,
        S_DIV,
        S_REDIV,
        S_PUSH,
        S_TAIL,
        S_FLUSH
    } t_state;

    t_state             r_state;
    logic [VALUE_W-1:0] r_rest;
    logic [PCNT_W-1:0]  r_idx;
    logic [SIEVE_W-1:0] r_p;
    logic [SQ_W-1:0]    r_psq;
    logic [EXP_W-1:0]   r_exp;
    logic [RCNT_W-1:0]  r_nres;
    logic               r_tail;

    // factor just found
    logic [PRIME_W-1:0] r_nf_p;
    logic [EXP_W-1:0]   r_nf_e;

    // factor waiting for its last flag
    logic               r_pend_v;
    logic [PRIME_W-1:0] r_pend_p;
    logic [EXP_W-1:0]   r_pend_e;

    // output register
    logic               r_ovalid;
    logic [PRIME_W-1:0] r_out_p;
    logic [EXP_W-1:0]   r_out_e;
    logic               r_out_last;

    logic               in_beat;
    logic               can_load;
    logic               out_load;
    logic               div_start;
    logic [SIEVE_W-1:0] tab_prime;
    t_div_res           div_res;
    t_sieve_stat        sv_stat;
    logic [VALUE_W-1:0] in_value;

    tdf_sieve u_sieve (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (r_idx[PIDX_W-1:0]),
        .o_rd_prime (tab_prime),
        .o_stat     (sv_stat)
    );

    tdf_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_rest),
        .i_divisor  (r_p),
        .o_res      (div_res)
    );

    assign in_value  = i_s_tdata[VALUE_W-1:0];
    assign o_s_tready = (r_state == S_IDLE) && sv_stat.done;
    assign in_beat   = i_s_tvalid && o_s_tready;
    assign can_load  = !r_ovalid || i_m_tready;
    // a pending factor moves into the output register this cycle
    assign out_load  = r_pend_v && can_load
                       && ((r_state == S_PUSH) || (r_state == S_FLUSH));
    assign div_start = ((r_state == S_CMP) && !(64'(r_psq) > 64'(r_rest)))
                       || (r_state == S_REDIV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // drop the output beat once taken unless a new one loads below
            if (r_ovalid && i_m_tready && !out_load) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_beat && (in_value != '0)) begin
                        r_rest  <= in_value;
                        r_idx   <= '0;
                        r_exp   <= '0;
                        r_nres  <= '0;
                        r_tail  <= 1'b0;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    // table read address is r_idx; data lands next cycle
                    r_state <= (r_idx >= sv_stat.count) ? S_TAIL : S_SQR;
                end
                S_SQR: begin
                    r_p     <= tab_prime;
                    r_psq   <= SQ_W'(tab_prime) * SQ_W'(tab_prime);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_state <= div_start ? S_DIV : S_TAIL;
                end
                S_DIV: begin
                    if (div_res.done) begin
                        if (div_res.rem_zero) begin
                            r_rest  <= div_res.quot;
                            r_exp   <= r_exp + 1'b1;
                            r_state <= S_REDIV;
                        end else if (r_exp != '0) begin
                            r_nf_p  <= PRIME_W'(r_p);
                            r_nf_e  <= r_exp;
                            r_state <= S_PUSH;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_REDIV: begin
                    r_state <= S_DIV;
                end
                S_PUSH: begin
                    // move the older factor out before taking the new one
                    if (!r_pend_v || can_load) begin
                        if (r_pend_v) begin
                            r_ovalid   <= 1'b1;
                            r_out_p    <= r_pend_p;
                            r_out_e    <= r_pend_e;
                            r_out_last <= 1'b0;
                        end
                        r_pend_v <= 1'b1;
                        r_pend_p <= r_nf_p;
                        r_pend_e <= r_nf_e;
                        r_nres   <= r_nres + 1'b1;
                        if ((r_nres + 1'b1) == RCNT_W'(MAX_RESULTS) || r_tail) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_exp   <= '0;
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_TAIL: begin
                    // leftover cofactor above one is prime
                    if (r_rest > VALUE_W'(1)) begin
                        r_nf_p  <= PRIME_W'(r_rest);
                        r_nf_e  <= EXP_W'(1);
                        r_tail  <= 1'b1;
                        r_state <= S_PUSH;
                    end else begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (can_load) begin
                        r_ovalid   <= 1'b1;
                        r_out_p    <= r_pend_p;
                        r_out_e    <= r_pend_e;
                        r_out_last <= 1'b1;
                        r_pend_v   <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_out_e, r_out_p};
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/tdf_checker.sv
// ----------------------------------------------------------------------------
// tdf_checker
// Port-level checks on the factorizer, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    input  wire logic                              i_s_tready,
    input  wire logic [tdf_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  wire logic                              i_m_tvalid,
    input  wire logic                              i_m_tready,
    input  wire logic [tdf_pkg::OUT_TDATA_W-1:0]   i_m_tdata,
    input  wire logic                              i_m_tlast
);
    import tdf_pkg::*;

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=>
            i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast))
        else $error("output beat changed while stalled");

    // every beat carries a real factor: prime of two or more, nonzero exponent, zero pad bits
    a_factor_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |->
            (i_m_tdata[PRIME_W-1:0] > PRIME_W'(1))
            && (i_m_tdata[PRIME_W+EXP_W-1:PRIME_W] != '0)
            && (i_m_tdata[OUT_TDATA_W-1:PRIME_W+EXP_W] == '0))
        else $error("output beat is not a valid factor");

    // the sieve must run after reset before any value is taken
    a_boot_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_s_tready)
        else $error("ready right after reset");

    // a value above one keeps the block busy for at least the next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready && (i_s_tdata[VALUE_W-1:0] > VALUE_W'(1))
            |=> !i_s_tready)
        else $error("ready right after taking a value to factor");

endmodule

bind trial_division_factorizer tdf_checker u_tdf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tlast  (o_m_tlast)
);

`default_nettype wire
